// ----- hw/rtl/prmu_pkg.sv -----
// Shared types, constants and helpers for the proximity RSSI map update block.
// No dependencies; imported by every prmu_* module and by the top level.
`default_nettype none

package prmu_pkg;

  localparam int NSLOT = 6;

  localparam logic [7:0] MARK_FF       = 8'hFF;
  localparam logic [7:0] CHECK_A5      = 8'hA5;
  localparam logic [7:0] RSSI_LOW      = 8'h10;
  localparam logic [7:0] RSSI_HIGH     = 8'hFE;
  localparam logic [7:0] GOOD_EVENT    = 8'h03;
  localparam logic [7:0] GOOD_LEN      = 8'h0D;
  localparam logic [7:0] MAP_TAG_RST   = 8'h20;
  localparam logic [7:0] PUB_TAG_RST   = 8'h1F;
  localparam logic [7:0] ROLL_TAG_RST  = 8'hFE;
  localparam logic [7:0] MAP_SLOT_FILL = 8'h00;
  localparam logic [7:0] PUB_SLOT_FILL = 8'h10;
  localparam logic [2:0] OWN_SLOT_RST  = 3'd6;

  localparam logic MODE_HEARD = 1'b0;
  localparam logic MODE_PUB   = 1'b1;
  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_PUB   = 1'b1;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic                 is_pub;
    logic [NSLOT-1:0]     upd_mask;
    logic [7:0]           rssi;
    logic [7:0]           head;
    logic [8*NSLOT-1:0]   slots;
    logic [7:0]           check;
    logic [7:0]           tag;
  } item_t;

  // Slot bytes filled with one value, own slot carrying the 0xFF mark.
  function automatic logic [8*NSLOT-1:0] slot_pattern(input logic [7:0] fill,
                                                      input logic [2:0] own);
    logic [8*NSLOT-1:0] v;
    for (int k = 0; k < NSLOT; k++) begin
      v[8*k +: 8] = (own == 3'(k + 1)) ? MARK_FF : fill;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/prmu_front.sv -----
// Front end: takes input beats, drops malformed reports, builds the slot update mask.
// Depends on prmu_pkg; pushes item_t into prmu_queue.
`default_nettype none

module prmu_front
  import prmu_pkg::*;
(
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic                 in_mode,
  input  wire logic [7:0]           in_event_type,
  input  wire logic [7:0]           in_data_length,
  input  wire logic [7:0]           in_rssi,
  input  wire logic [7:0]           in_head_byte,
  input  wire logic [8*NSLOT-1:0]   in_slot_bytes,
  input  wire logic [7:0]           in_check_byte,
  input  wire logic [7:0]           in_tag_byte,
  input  wire logic                 q_full,
  output      logic                 q_push,
  output      item_t                q_item
);

  logic heard_ok;
  logic rssi_ok;

  assign heard_ok = (in_mode == MODE_HEARD) && (in_event_type == GOOD_EVENT) &&
                    (in_data_length == GOOD_LEN) && (in_head_byte == MARK_FF);
  assign rssi_ok  = (in_rssi > RSSI_LOW) && (in_rssi < RSSI_HIGH);

  assign in_stall = q_full;
  // Drop rejected reports here; they never reach the back end.
  assign q_push   = in_valid && !q_full && ((in_mode == MODE_PUB) || heard_ok);

  always_comb begin
    q_item.is_pub = (in_mode == MODE_PUB);
    q_item.rssi   = in_rssi;
    q_item.head   = in_head_byte;
    q_item.slots  = in_slot_bytes;
    q_item.check  = in_check_byte;
    q_item.tag    = in_tag_byte;
    for (int k = 0; k < NSLOT; k++) begin
      q_item.upd_mask[k] = rssi_ok && (in_slot_bytes[8*k +: 8] == MARK_FF);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/prmu_queue.sv -----
// Short FIFO of classified items between the front and back ends.
// Depends on prmu_pkg for item_t.
`default_nettype none

module prmu_queue
  import prmu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  not_empty,
  output      item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/prmu_back.sv -----
// Back end: holds the map, last heard and last published copies and the rolling tag,
// executes one queued item per cycle into the output register unless stalled. Depends on prmu_pkg.
`default_nettype none

module prmu_back
  import prmu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [2:0]           cfg_wr_data,
  input  wire logic                 q_not_empty,
  input  wire item_t                q_item,
  output      logic                 q_pop,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic                 out_kind,
  output      logic                 out_changed,
  output      logic [7:0]           out_head,
  output      logic [8*NSLOT-1:0]   out_slots,
  output      logic [7:0]           out_check,
  output      logic [7:0]           out_tag
);

  logic [8*NSLOT-1:0] map_slots_r, map_slots_nxt;
  logic [7:0]         map_tag_r, map_tag_nxt;
  logic [8*NSLOT-1:0] pub_slots_r, pub_slots_nxt;
  logic [7:0]         pub_tag_r, pub_tag_nxt;
  logic [8*9-1:0]     heard_r, heard_nxt;
  logic [7:0]         tag_r, tag_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic               out_changed_r, out_changed_nxt;
  logic [7:0]         out_head_r, out_head_nxt;
  logic [8*NSLOT-1:0] out_slots_r, out_slots_nxt;
  logic [7:0]         out_check_r, out_check_nxt;
  logic [7:0]         out_tag_r, out_tag_nxt;

  logic               take;
  logic [8*9-1:0]     rx_bytes;
  logic               pub_same;
  logic [7:0]         tag_inc;

  assign take     = q_not_empty && (!out_valid_r || !out_stall);
  assign q_pop    = take;
  assign rx_bytes = {q_item.tag, q_item.check, q_item.slots, q_item.head};
  assign pub_same = (map_slots_r == pub_slots_r) && (map_tag_r == pub_tag_r);
  assign tag_inc  = ((tag_r + 8'd1) == MARK_FF) ? 8'd0 : tag_r + 8'd1;

  always_comb begin
    map_slots_nxt   = map_slots_r;
    map_tag_nxt     = map_tag_r;
    pub_slots_nxt   = pub_slots_r;
    pub_tag_nxt     = pub_tag_r;
    heard_nxt       = heard_r;
    tag_nxt         = tag_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_kind_nxt    = out_kind_r;
    out_changed_nxt = out_changed_r;
    out_head_nxt    = out_head_r;
    out_slots_nxt   = out_slots_r;
    out_check_nxt   = out_check_r;
    out_tag_nxt     = out_tag_r;

    if (take) begin
      if (!q_item.is_pub) begin
        for (int k = 0; k < NSLOT; k++) begin
          if (q_item.upd_mask[k]) begin
            map_slots_nxt[8*k +: 8] = q_item.rssi;
          end
        end
        // Echo only a report that differs from the last one heard.
        if (rx_bytes != heard_r) begin
          heard_nxt       = rx_bytes;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_ECHO;
          out_changed_nxt = 1'b1;
          out_head_nxt    = q_item.head;
          out_slots_nxt   = q_item.slots;
          out_check_nxt   = q_item.check;
          out_tag_nxt     = q_item.tag;
        end
      end else begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = KIND_PUB;
        out_changed_nxt = !pub_same;
        out_head_nxt    = MARK_FF;
        out_slots_nxt   = map_slots_r;
        out_check_nxt   = CHECK_A5;
        out_tag_nxt     = map_tag_r;
        // Advance the tag, skipping 0xFF, when the map moved since the last publish.
        if (!pub_same) begin
          tag_nxt       = tag_inc;
          map_tag_nxt   = tag_inc;
          pub_tag_nxt   = tag_inc;
          pub_slots_nxt = map_slots_r;
          out_tag_nxt   = tag_inc;
        end
      end
    end

    if (cfg_wr_en) begin
      map_slots_nxt = slot_pattern(MAP_SLOT_FILL, cfg_wr_data);
      map_tag_nxt   = MAP_TAG_RST;
      pub_slots_nxt = slot_pattern(PUB_SLOT_FILL, cfg_wr_data);
      pub_tag_nxt   = PUB_TAG_RST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_slots_r <= slot_pattern(MAP_SLOT_FILL, OWN_SLOT_RST);
      map_tag_r   <= MAP_TAG_RST;
      pub_slots_r <= slot_pattern(PUB_SLOT_FILL, OWN_SLOT_RST);
      pub_tag_r   <= PUB_TAG_RST;
      heard_r     <= '0;
      tag_r       <= ROLL_TAG_RST;
      out_valid_r <= 1'b0;
    end else begin
      map_slots_r <= map_slots_nxt;
      map_tag_r   <= map_tag_nxt;
      pub_slots_r <= pub_slots_nxt;
      pub_tag_r   <= pub_tag_nxt;
      heard_r     <= heard_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r    <= out_kind_nxt;
    out_changed_r <= out_changed_nxt;
    out_head_r    <= out_head_nxt;
    out_slots_r   <= out_slots_nxt;
    out_check_r   <= out_check_nxt;
    out_tag_r     <= out_tag_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_changed = out_changed_r;
  assign out_head    = out_head_r;
  assign out_slots   = out_slots_r;
  assign out_check   = out_check_r;
  assign out_tag     = out_tag_r;

  a_tag_never_ff: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r != MARK_FF)
    else $error("rolling tag reached the reserved value");

  a_echo_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_ECHO)) |-> out_changed_r)
    else $error("echo presented without changed flag");

  a_pub_tag_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_item.is_pub && !pub_same && !cfg_wr_en) |=>
      (map_tag_r == tag_r) && (pub_tag_r == tag_r) && (out_tag_r == tag_r))
    else $error("publish with change left tag copies out of step");

  a_pub_then_same: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_item.is_pub && !cfg_wr_en) |=> pub_same)
    else $error("published copy differs from map right after publish");

endmodule

`default_nettype wire

// ----- hw/rtl/proximity_rssi_map_update_core.sv -----
// Top level of the proximity RSSI map update block.
// Depends on prmu_pkg, prmu_front, prmu_queue and prmu_back.
//
//  channel | ports                          | direction | beat
//  --------+--------------------------------+-----------+------------------------------
//  in      | in_valid / in_stall + fields   | sink      | heard report or publish request
//  out     | out_valid / out_stall + fields | source    | echo or published map
//  cfg     | cfg_wr_en / cfg_wr_data        | sink      | own slot write, no read-back
//
// One item per cycle sustained while out_stall is low; an accepted beat that passes the checks
// is queued, and the back end then loads its result, if any, into the output register.
// Queue depth QUEUE_DEPTH decouples input acceptance from output stalls.
// Reset (synchronous, rst_n low) loads the map with own slot 6 and empties the queue.
// out_stall holds the output register; in_stall rises once the queue is full.
`default_nettype none

module proximity_rssi_map_update_core
  import prmu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [2:0]           cfg_wr_data,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic                 in_mode,
  input  wire logic [7:0]           in_event_type,
  input  wire logic [7:0]           in_data_length,
  input  wire logic [7:0]           in_rssi,
  input  wire logic [7:0]           in_head_byte,
  input  wire logic [8*NSLOT-1:0]   in_slot_bytes,
  input  wire logic [7:0]           in_check_byte,
  input  wire logic [7:0]           in_tag_byte,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic                 out_kind,
  output      logic                 out_changed,
  output      logic [7:0]           out_head,
  output      logic [8*NSLOT-1:0]   out_slots,
  output      logic [7:0]           out_check,
  output      logic [7:0]           out_tag
);

  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_head_item;

  prmu_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_event_type  (in_event_type),
    .in_data_length (in_data_length),
    .in_rssi        (in_rssi),
    .in_head_byte   (in_head_byte),
    .in_slot_bytes  (in_slot_bytes),
    .in_check_byte  (in_check_byte),
    .in_tag_byte    (in_tag_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_push_item)
  );

  prmu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item)
  );

  prmu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_item      (q_head_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_changed (out_changed),
    .out_head    (out_head),
    .out_slots   (out_slots),
    .out_check   (out_check),
    .out_tag     (out_tag)
  );

endmodule

`default_nettype wire

// ----- sim/proximity_rssi_map_update_core_test.sv -----
// Self-checking testbench for proximity_rssi_map_update_core.
// Depends on prmu_pkg and the core RTL. It keeps its own model of the map and checks
// every result beat against it, under random idles on both sides.
`timescale 1ns / 1ps

module proximity_rssi_map_update_core_test;
  import prmu_pkg::*;

  typedef struct {
    logic        mode;
    logic [7:0]  ev;
    logic [7:0]  len;
    logic [7:0]  rssi;
    logic [7:0]  head;
    logic [47:0] slots;
    logic [7:0]  chk;
    logic [7:0]  tag;
  } report_t;

  typedef struct {
    logic        kind;
    logic        changed;
    logic [7:0]  head;
    logic [47:0] slots;
    logic [7:0]  chk;
    logic [7:0]  tag;
  } map_packet_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [7:0]  in_event_type = '0;
  logic [7:0]  in_data_length = '0;
  logic [7:0]  in_rssi = '0;
  logic [7:0]  in_head_byte = '0;
  logic [47:0] in_slot_bytes = '0;
  logic [7:0]  in_check_byte = '0;
  logic [7:0]  in_tag_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic        out_changed;
  logic [7:0]  out_head;
  logic [47:0] out_slots;
  logic [7:0]  out_check;
  logic [7:0]  out_tag;

  proximity_rssi_map_update_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_event_type (in_event_type),
    .in_data_length(in_data_length),
    .in_rssi       (in_rssi),
    .in_head_byte  (in_head_byte),
    .in_slot_bytes (in_slot_bytes),
    .in_check_byte (in_check_byte),
    .in_tag_byte   (in_tag_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_changed   (out_changed),
    .out_head      (out_head),
    .out_slots     (out_slots),
    .out_check     (out_check),
    .out_tag       (out_tag)
  );

  // Model state
  logic [2:0] own_slot_m;
  logic [7:0] map_b  [9];
  logic [7:0] pub_b  [9];
  logic [7:0] heard_b[9];
  logic [7:0] tag_r;

  report_t     pending_reports[$];
  map_packet_t expected_packets[$];
  report_t     cur_report;
  map_packet_t oldest_packet;
  report_t     last_good;
  bit          have_good = 0;

  int idle_pct = 6;
  bit hold_req = 0;
  bit hold_seen = 0;
  int hold_count = 0;

  int n_errors = 0;
  int n_beats = 0;
  int n_rejected = 0;
  int n_repeat = 0;
  int n_echo = 0;
  int n_pub = 0;
  int n_in_stalled = 0;
  int n_settings = 0;

  logic [2:0] own_settings[8] = '{3'd1, 3'd7, 3'd0, 3'd4, 3'd2, 3'd5, 3'd3, 3'd6};

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("proximity_rssi_map_update_core regression: fail");
    $finish;
  end

  task automatic reload_maps();
    int k;
    for (k = 0; k < 9; k++) begin
      map_b[k] = (k == 0) ? MARK_FF : (k == 7) ? CHECK_A5 : (k == 8) ? MAP_TAG_RST : MAP_SLOT_FILL;
      pub_b[k] = (k == 0) ? MARK_FF : (k == 7) ? CHECK_A5 : (k == 8) ? PUB_TAG_RST : PUB_SLOT_FILL;
    end
    if (own_slot_m >= 3'd1 && own_slot_m <= 3'd6) begin
      map_b[own_slot_m] = MARK_FF;
      pub_b[own_slot_m] = MARK_FF;
    end
  endtask

  task automatic predict_map_update(input report_t b);
    map_packet_t r;
    logic [7:0]  rx[9];
    bit          same;
    int          k;
    same = 1;
    if (b.mode == MODE_HEARD) begin
      if (b.ev != GOOD_EVENT || b.len != GOOD_LEN || b.head != MARK_FF) begin
        n_rejected++;
        return;
      end
      rx[0] = b.head;
      for (k = 1; k <= 6; k++) rx[k] = b.slots[8*(k-1) +: 8];
      rx[7] = b.chk;
      rx[8] = b.tag;
      for (k = 1; k <= 6; k++) begin
        if (rx[k] == MARK_FF && b.rssi < RSSI_HIGH && b.rssi > RSSI_LOW) map_b[k] = b.rssi;
      end
      for (k = 0; k < 9; k++) begin
        if (rx[k] != heard_b[k]) begin
          same = 0;
          heard_b[k] = rx[k];
        end
      end
      // drop repeats: slot updates above still apply
      if (same) begin
        n_repeat++;
        return;
      end
      r.kind = KIND_ECHO;
      r.changed = 1'b1;
    end else begin
      for (k = 0; k < 9; k++) begin
        if (map_b[k] != pub_b[k]) begin
          same = 0;
          pub_b[k] = map_b[k];
        end
      end
      if (!same) begin
        tag_r = tag_r + 8'd1;
        if (tag_r == MARK_FF) tag_r = tag_r + 8'd1;
        map_b[8] = tag_r;
        pub_b[8] = tag_r;
      end
      for (k = 0; k < 9; k++) rx[k] = map_b[k];
      r.kind = KIND_PUB;
      r.changed = !same;
    end
    r.head = rx[0];
    for (k = 1; k <= 6; k++) r.slots[8*(k-1) +: 8] = rx[k];
    r.chk = rx[7];
    r.tag = rx[8];
    expected_packets.push_back(r);
  endtask

  function automatic logic [7:0] pick_rssi();
    logic [7:0] edges[6] = '{8'h10, 8'h11, 8'hFD, 8'hFE, 8'hFF, 8'h00};
    if ($urandom_range(99, 0) < 30) return edges[$urandom_range(5, 0)];
    return 8'($urandom);
  endfunction

  function automatic logic [47:0] pick_slots();
    logic [47:0] s;
    int k;
    for (k = 0; k < 6; k++) s[8*k +: 8] = ($urandom_range(99, 0) < 45) ? MARK_FF : 8'($urandom);
    return s;
  endfunction

  function automatic report_t good_report(input logic [47:0] slots, input logic [7:0] rssi,
                                          input logic [7:0] chk, input logic [7:0] tag);
    report_t b;
    b.mode = MODE_HEARD;
    b.ev = GOOD_EVENT;
    b.len = GOOD_LEN;
    b.head = MARK_FF;
    b.rssi = rssi;
    b.slots = slots;
    b.chk = chk;
    b.tag = tag;
    return b;
  endfunction

  function automatic report_t publish_beat();
    report_t b;
    b.mode = MODE_PUB;
    b.ev = 8'($urandom);
    b.len = 8'($urandom);
    b.rssi = 8'($urandom);
    b.head = 8'($urandom);
    b.slots = 48'({$urandom, $urandom});
    b.chk = 8'($urandom);
    b.tag = 8'($urandom);
    return b;
  endfunction

  function automatic report_t random_beat();
    report_t b;
    int pick;
    pick = $urandom_range(99, 0);
    b = good_report(pick_slots(), pick_rssi(),
                    ($urandom_range(1, 0) != 0) ? CHECK_A5 : 8'($urandom), 8'($urandom));
    if (pick < 15) begin
      b = publish_beat();
    end else if (pick < 20) begin
      b = publish_beat();
      b.mode = 1'($urandom_range(1, 0));
    end else if (pick < 30) begin
      // break exactly one header field of an otherwise good report
      case ($urandom_range(2, 0))
        0: while (b.ev == GOOD_EVENT) b.ev = 8'($urandom);
        1: while (b.len == GOOD_LEN) b.len = 8'($urandom);
        default: while (b.head == MARK_FF) b.head = 8'($urandom);
      endcase
    end else if (pick < 42 && have_good) begin
      b = last_good;
      if ($urandom_range(1, 0) != 0) b.rssi = pick_rssi();
    end else begin
      last_good = b;
      have_good = 1;
    end
    return b;
  endfunction

  task automatic write_own_slot(input logic [2:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_slot_m = v;
    reload_maps();
    n_settings++;
  endtask

  // Hold until every beat is in and every result is out, then let the pipe empty.
  task automatic drain();
    while (pending_reports.size() != 0 || in_valid || expected_packets.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) n_in_stalled++;
      if (in_valid && !in_stall) begin
        predict_map_update(cur_report);
        n_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reports.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          cur_report = pending_reports.pop_front();
          in_mode <= cur_report.mode;
          in_event_type <= cur_report.ev;
          in_data_length <= cur_report.len;
          in_rssi <= cur_report.rssi;
          in_head_byte <= cur_report.head;
          in_slot_bytes <= cur_report.slots;
          in_check_byte <= cur_report.chk;
          in_tag_byte <= cur_report.tag;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_seen) hold_count = 200;
      hold_seen = hold_req;
      if (hold_count > 0) hold_count--;
      out_stall <= (hold_count > 0) || ($urandom_range(99, 0) < idle_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_packets.size() == 0) begin
        $error("result beat with nothing expected: kind %0d tag %0h", out_kind, out_tag);
        n_errors++;
      end else begin
        oldest_packet = expected_packets.pop_front();
        check_field("out_kind", 48'(oldest_packet.kind), 48'(out_kind));
        check_field("out_changed", 48'(oldest_packet.changed), 48'(out_changed));
        check_field("out_head", 48'(oldest_packet.head), 48'(out_head));
        check_field("out_slots", oldest_packet.slots, out_slots);
        check_field("out_check", 48'(oldest_packet.chk), 48'(out_check));
        check_field("out_tag", 48'(oldest_packet.tag), 48'(out_tag));
        if (oldest_packet.kind == KIND_PUB) n_pub++;
        else n_echo++;
      end
    end
  end

  initial begin
    int p;
    own_slot_m = OWN_SLOT_RST;
    reload_maps();
    for (p = 0; p < 9; p++) heard_b[p] = 8'h00;
    tag_r = ROLL_TAG_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset state
    pending_reports.push_back(publish_beat());      // changed, tag wraps past 0xFF
    pending_reports.push_back(publish_beat());      // nothing new
    pending_reports.push_back(good_report({6{MARK_FF}}, 8'h11, CHECK_A5, 8'h01));
    pending_reports.push_back(good_report({6{MARK_FF}}, 8'h11, CHECK_A5, 8'h01));
    pending_reports.push_back(good_report({6{MARK_FF}}, RSSI_LOW, CHECK_A5, 8'h02));
    pending_reports.push_back(good_report({6{MARK_FF}}, RSSI_HIGH, CHECK_A5, 8'h03));
    pending_reports.push_back(good_report({6{MARK_FF}}, 8'hFD, CHECK_A5, 8'h04));
    pending_reports.push_back(good_report({6{MARK_FF}}, 8'hFF, 8'h00, 8'hFF));
    pending_reports.push_back(good_report(48'h0, 8'h80, 8'hFF, 8'h00));
    pending_reports.push_back(good_report(48'hFF00_0000_00FF, 8'h40, CHECK_A5, 8'h05));
    begin
      report_t b;
      b = good_report({6{MARK_FF}}, 8'h30, CHECK_A5, 8'h06);
      b.ev = 8'h00;   pending_reports.push_back(b);
      b.ev = 8'hFF;   pending_reports.push_back(b);
      b.ev = GOOD_EVENT;
      b.len = 8'h0C;  pending_reports.push_back(b);
      b.len = 8'hFF;  pending_reports.push_back(b);
      b.len = 8'h00;  pending_reports.push_back(b);
      b.len = GOOD_LEN;
      b.head = 8'hFE; pending_reports.push_back(b);
      b.head = 8'h00; pending_reports.push_back(b);
    end
    pending_reports.push_back(publish_beat());
    pending_reports.push_back(publish_beat());
    pending_reports.push_back(good_report(48'hFF00_0000_00FF, 8'h20, CHECK_A5, 8'h05));
    pending_reports.push_back(publish_beat());
    drain();

    // Random phases, one own-slot setting each
    for (p = 0; p < 8; p++) begin
      write_own_slot(own_settings[p]);
      if (p == 1) hold_req <= 1'b1;
      if (p == 2) idle_pct <= 0;
      if (p == 3) idle_pct <= 6;
      repeat (63) pending_reports.push_back(random_beat());
      drain();
    end

    if (expected_packets.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_packets.size());
      n_errors++;
    end
    $display("covered %0d input beats under %0d own-slot settings: %0d echoes, %0d publishes",
             n_beats, n_settings + 1, n_echo, n_pub);
    $display("%0d rejected and %0d repeated reports; input stalled for %0d cycles",
             n_rejected, n_repeat, n_in_stalled);
    if (n_errors == 0) begin
      $display("proximity_rssi_map_update_core regression: pass");
    end else begin
      $display("proximity_rssi_map_update_core regression: fail");
    end
    $finish;
  end

endmodule
